[hdl/tnqc_pkg.sv]
package tnqc_pkg;

  localparam int MAX_TRIS_DEF = 16;
  localparam int COORD_W      = 24;
  localparam int SUM_W        = 40;
  localparam int COST_W       = 32;
  localparam int IN_DATA_W    = 6 * COORD_W;
  localparam int DIV_W        = 40;
  localparam int RATIO_STEPS  = 17;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam logic [17:0] TWO_SQRT3_Q16 = 18'd227023;

  // Product select codes for the shared multiplier.
  localparam logic [2:0] MS_UXVY = 3'd0;
  localparam logic [2:0] MS_VXUY = 3'd1;
  localparam logic [2:0] MS_UXUX = 3'd2;
  localparam logic [2:0] MS_UYUY = 3'd3;
  localparam logic [2:0] MS_VXVX = 3'd4;
  localparam logic [2:0] MS_VYVY = 3'd5;
  localparam logic [2:0] MS_WXWX = 3'd6;
  localparam logic [2:0] MS_WYWY = 3'd7;

  typedef struct packed {
    logic       load_in;
    logic       diff_en;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_en;
    logic [2:0] acc_sel;
    logic       prep_en;
    logic       neg_sq;
    logic       rmul_lo;
    logic       rmul_hi;
    logic       rsum;
    logic       q_load_clamp;
    logic       q_load_zero;
    logic       q_load_div;
    logic       q_sq;
    logic       acc_tri;
    logic       div_start;
    logic       div_avg;
    logic       avg_load;
    logic       fr1;
    logic       fr2;
    logic       fr3;
    logic       fw0;
    logic       fw1;
    logic       ftot;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic j_neg;
    logic s_zero;
    logic ratio_clamp;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/tnqc_div.sv]
module tnqc_div
  import tnqc_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(W+1)-1:0]     steps_i,
  input  logic [W-1:0]               divisor_i,
  input  logic [W-1:0]               rem_i,
  input  logic [W-1:0]               num_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [W-1:0]               quot_o
);

  localparam int CW = $clog2(W+1);

  logic [W-1:0]  rem_q, rem_d, num_q, num_d, quot_q, quot_d, div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    rem_sh, rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, num_q[W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      num_d  = num_i;
      quot_d = '0;
      div_d  = divisor_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      num_d  = {num_q[W-2:0], 1'b0};
      quot_d = {quot_q[W-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/tnqc_dp.sv]
module tnqc_dp
  import tnqc_pkg::*;
#(
  parameter int MAX_TRIS = MAX_TRIS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [COST_W-1:0]    out_cost_o,
  output logic                 out_inv_o
);

  localparam int CNT_W = $clog2(MAX_TRIS + 1);
  localparam int DCW   = $clog2(DIV_W + 1);

  logic signed [23:0] xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;
  logic signed [24:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic signed [24:0] op_a, op_b;
  logic signed [49:0] prod, p_q, j_q;
  logic [50:0]        s_q;
  logic [3:0]         k;
  logic [39:0]        sn_q;
  logic [49:0]        jn_q, j_u, negj;
  logic [50:0]        mneg;
  logic [23:0]        t_q;
  logic               sat_q;
  logic [42:0]        plo_q, phi_q;
  logic [67:0]        dvd_q;
  logic [16:0]        q_q, dq;
  logic [33:0]        dd;
  logic [47:0]        tt;
  logic [COST_W-1:0]  cost_q, res_q;
  logic [SUM_W-1:0]   sum_q, avg_q;
  logic [COST_W-1:0]  max_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;
  logic [16:0]        m17, w_q;
  logic [17:0]        mm_q, r_q, m4_q;
  logic [33:0]        mprod;
  logic [36:0]        pwl_q, pwh_q;
  logic [56:0]        pw;
  logic [41:0]        tot;
  logic               out_valid_q;
  logic [COST_W-1:0]  out_cost_q;
  logic               out_inv_q;

  logic [DCW-1:0]     dv_steps;
  logic [DIV_W-1:0]   dv_div, dv_rem, dv_num, dv_quot;
  logic               dv_busy, dv_done;

  tnqc_div #(.W(DIV_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .steps_i   (dv_steps),
    .divisor_i (dv_div),
    .rem_i     (dv_rem),
    .num_i     (dv_num),
    .busy_o    (dv_busy),
    .done_o    (dv_done),
    .quot_o    (dv_quot)
  );

  always_comb begin
    if (cmd_i.div_avg) begin
      dv_steps = DCW'(SUM_W);
      dv_rem   = '0;
      dv_num   = sum_q;
      dv_div   = (cnt_q == '0) ? DIV_W'(1) : DIV_W'(cnt_q);
    end else begin
      dv_steps = DCW'(RATIO_STEPS);
      dv_rem   = dvd_q[56:17];
      dv_num   = {dvd_q[16:0], 23'b0};
      dv_div   = sn_q;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_UXVY: begin op_a = ux_q; op_b = vy_q; end
      MS_VXUY: begin op_a = vx_q; op_b = uy_q; end
      MS_UXUX: begin op_a = ux_q; op_b = ux_q; end
      MS_UYUY: begin op_a = uy_q; op_b = uy_q; end
      MS_VXVX: begin op_a = vx_q; op_b = vx_q; end
      MS_VYVY: begin op_a = vy_q; op_b = vy_q; end
      MS_WXWX: begin op_a = wx_q; op_b = wx_q; end
      MS_WYWY: begin op_a = wy_q; op_b = wy_q; end
      default: begin op_a = ux_q; op_b = vy_q; end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    k = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (s_q[40+i]) k = 4'(i + 1);
    end
  end

  assign j_u   = $unsigned(j_q);
  assign negj  = $unsigned(-j_q);
  assign mneg  = {1'b0, negj} + (51'd1 << 32);
  assign tt    = t_q * t_q;
  assign dq    = ONE_Q16 - q_q;
  assign dd    = dq * dq;
  assign m17   = max_q[16:0];
  assign pw    = {pwh_q, 20'b0} + {20'b0, pwl_q};
  assign tot   = {24'b0, m4_q} + {1'b0, pw[56:16]};

  always_comb begin
    mprod = '0;
    if (cmd_i.fr1) mprod = m17 * m17;
    else if (cmd_i.fr2) mprod = mm_q[16:0] * m17;
    else if (cmd_i.fr3) mprod = r_q[16:0] * m17;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xa_q <= in_data_i[23:0];
      ya_q <= in_data_i[47:24];
      xb_q <= in_data_i[71:48];
      yb_q <= in_data_i[95:72];
      xc_q <= in_data_i[119:96];
      yc_q <= in_data_i[143:120];
    end
    if (cmd_i.diff_en) begin
      ux_q <= {xb_q[23], xb_q} - {xa_q[23], xa_q};
      uy_q <= {yb_q[23], yb_q} - {ya_q[23], ya_q};
      vx_q <= {xc_q[23], xc_q} - {xa_q[23], xa_q};
      vy_q <= {yc_q[23], yc_q} - {ya_q[23], ya_q};
      wx_q <= {xc_q[23], xc_q} - {xb_q[23], xb_q};
      wy_q <= {yc_q[23], yc_q} - {yb_q[23], yb_q};
    end
    if (cmd_i.mul_en) p_q <= prod;
    if (cmd_i.acc_en) begin
      case (cmd_i.acc_sel)
        MS_UXVY: j_q <= p_q;
        MS_VXUY: j_q <= j_q - p_q;
        MS_UXUX: s_q <= 51'($unsigned(p_q));
        default: s_q <= s_q + 51'($unsigned(p_q));
      endcase
    end
    if (cmd_i.prep_en) begin
      sn_q  <= 40'(s_q >> k);
      jn_q  <= j_u >> k;
      t_q   <= mneg[39:16];
      sat_q <= |mneg[50:40];
    end
    if (cmd_i.neg_sq) cost_q <= sat_q ? '1 : tt[47:16];
    if (cmd_i.rmul_lo) plo_q <= jn_q[24:0] * TWO_SQRT3_Q16;
    if (cmd_i.rmul_hi) phi_q <= jn_q[49:25] * TWO_SQRT3_Q16;
    if (cmd_i.rsum) dvd_q <= {phi_q, 25'b0} + {25'b0, plo_q};
    if (cmd_i.q_load_clamp) q_q <= ONE_Q16;
    else if (cmd_i.q_load_zero) q_q <= '0;
    else if (cmd_i.q_load_div) q_q <= (dv_quot[16:0] > ONE_Q16) ? ONE_Q16 : dv_quot[16:0];
    if (cmd_i.q_sq) cost_q <= {14'b0, dd[33:16]};
    if (cmd_i.avg_load) avg_q <= dv_quot;
    if (cmd_i.fr1) mm_q <= mprod[33:16];
    if (cmd_i.fr2) r_q <= mprod[33:16];
    if (cmd_i.fr3) begin
      m4_q <= mprod[33:16];
      w_q  <= (r_q >= {1'b0, ONE_Q16}) ? '0 : 17'({1'b0, ONE_Q16} - r_q);
    end
    if (cmd_i.fw0) pwl_q <= w_q * avg_q[19:0];
    if (cmd_i.fw1) pwh_q <= w_q * avg_q[39:20];
    if (cmd_i.ftot) begin
      if (max_q > COST_W'(ONE_Q16)) res_q <= max_q;
      else res_q <= (|tot[41:32]) ? '1 : tot[31:0];
    end
    if (cmd_i.out_load) begin
      out_cost_q <= res_q;
      out_inv_q  <= neg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        sum_q <= '0;
        max_q <= '0;
        cnt_q <= '0;
        neg_q <= 1'b0;
      end else if (cmd_i.acc_tri) begin
        sum_q <= sum_q + SUM_W'(cost_q);
        if (cost_q > max_q) max_q <= cost_q;
        cnt_q <= cnt_q + CNT_W'(1);
        if (j_q[49]) neg_q <= 1'b1;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.full        = (cnt_q == CNT_W'(MAX_TRIS));
  assign sts_o.j_neg       = j_q[49];
  assign sts_o.s_zero      = (s_q == '0);
  assign sts_o.ratio_clamp = dvd_q >= {11'b0, sn_q, 17'b0};
  assign sts_o.div_busy    = dv_busy;
  assign sts_o.div_done    = dv_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_cost_o  = out_cost_q;
  assign out_inv_o   = out_inv_q;

endmodule

[hdl/tnqc_ctrl.sv]
module tnqc_ctrl
  import tnqc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIFF  = 5'd1;
  localparam logic [4:0] ST_MUL   = 5'd2;
  localparam logic [4:0] ST_PREP  = 5'd3;
  localparam logic [4:0] ST_NEGSQ = 5'd4;
  localparam logic [4:0] ST_RMUL0 = 5'd5;
  localparam logic [4:0] ST_RMUL1 = 5'd6;
  localparam logic [4:0] ST_RSUM  = 5'd7;
  localparam logic [4:0] ST_RCHK  = 5'd8;
  localparam logic [4:0] ST_RDIV  = 5'd9;
  localparam logic [4:0] ST_QSQ   = 5'd10;
  localparam logic [4:0] ST_ACC   = 5'd11;
  localparam logic [4:0] ST_AVG   = 5'd12;
  localparam logic [4:0] ST_AVGW  = 5'd13;
  localparam logic [4:0] ST_FR1   = 5'd14;
  localparam logic [4:0] ST_FR2   = 5'd15;
  localparam logic [4:0] ST_FR3   = 5'd16;
  localparam logic [4:0] ST_FW0   = 5'd17;
  localparam logic [4:0] ST_FW1   = 5'd18;
  localparam logic [4:0] ST_FTOT  = 5'd19;
  localparam logic [4:0] ST_FOUT  = 5'd20;

  logic [4:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       last_q, last_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.full) begin
            if (in_last_i) state_d = ST_AVG;
          end else begin
            cmd_o.load_in = 1'b1;
            last_d        = in_last_i;
            state_d       = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        step_d        = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en  = !step_q[3];
        cmd_o.mul_sel = step_q[2:0];
        cmd_o.acc_en  = (step_q != '0);
        cmd_o.acc_sel = 3'(step_q - 4'd1);
        step_d        = step_q + 4'd1;
        if (step_q[3]) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep_en = 1'b1;
        if (sts_i.j_neg) begin
          state_d = ST_NEGSQ;
        end else if (sts_i.s_zero) begin
          cmd_o.q_load_zero = 1'b1;
          state_d           = ST_QSQ;
        end else begin
          state_d = ST_RMUL0;
        end
      end
      ST_NEGSQ: begin
        cmd_o.neg_sq = 1'b1;
        state_d      = ST_ACC;
      end
      ST_RMUL0: begin
        cmd_o.rmul_lo = 1'b1;
        state_d       = ST_RMUL1;
      end
      ST_RMUL1: begin
        cmd_o.rmul_hi = 1'b1;
        state_d       = ST_RSUM;
      end
      ST_RSUM: begin
        cmd_o.rsum = 1'b1;
        state_d    = ST_RCHK;
      end
      ST_RCHK: begin
        if (sts_i.ratio_clamp) begin
          cmd_o.q_load_clamp = 1'b1;
          state_d            = ST_QSQ;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (sts_i.div_done) begin
          cmd_o.q_load_div = 1'b1;
          state_d          = ST_QSQ;
        end
      end
      ST_QSQ: begin
        cmd_o.q_sq = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_tri = 1'b1;
        state_d       = last_q ? ST_AVG : ST_IDLE;
      end
      ST_AVG: begin
        cmd_o.div_avg   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_AVGW;
      end
      ST_AVGW: begin
        if (sts_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_FR1;
        end
      end
      ST_FR1: begin
        cmd_o.fr1 = 1'b1;
        state_d   = ST_FR2;
      end
      ST_FR2: begin
        cmd_o.fr2 = 1'b1;
        state_d   = ST_FR3;
      end
      ST_FR3: begin
        cmd_o.fr3 = 1'b1;
        state_d   = ST_FW0;
      end
      ST_FW0: begin
        cmd_o.fw0 = 1'b1;
        state_d   = ST_FW1;
      end
      ST_FW1: begin
        cmd_o.fw1 = 1'b1;
        state_d   = ST_FTOT;
      end
      ST_FTOT: begin
        cmd_o.ftot = 1'b1;
        state_d    = ST_FOUT;
      end
      ST_FOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

endmodule

[hdl/triangle_node_quality_cost_top.sv]
// Mesh node quality cost. Each input beat carries one triangle around a node
// as six signed Q8.16 coordinates, with tlast marking the final triangle.
// Each triangle's mean-ratio cost is folded into a running sum, a maximum and
// a count; the beat with tlast produces one output beat holding the node cost
// in unsigned Q16.16 and, in tuser, a flag for any inverted triangle.
// An inverted or degenerate triangle skips the ratio; any other triangle
// waits on the 17 steps of the shared restoring divider that forms the
// quality ratio unless the ratio clamps at one. On the final beat the same
// divider then computes the average cost over the node. The input takes
// one beat at a time, ready again when the previous triangle is folded in.
// Triangles beyond the per-node limit are counted out and leave the state
// unchanged. The result sits in an output register, so a stalled receiver only
// holds the block when a second result is ready before the first is taken.
// Reset clears the accumulators and the output valid flag.
module triangle_node_quality_cost_top
  import tnqc_pkg::*;
#(
  parameter int MAX_TRIS_PER_NODE = MAX_TRIS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // x_a, y_a, x_b, y_b, x_c, y_c from the lowest bit up.
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // last_triangle.
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // node_cost.
  output logic [COST_W-1:0]    m_axis_tdata,
  // inverted_seen.
  output logic                 m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  tnqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tnqc_dp #(.MAX_TRIS(MAX_TRIS_PER_NODE)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_cost_o  (m_axis_tdata),
    .out_inv_o   (m_axis_tuser)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after a final triangle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote an untaken output beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

endmodule
